// File: rtl/tpc_pkg.sv
`timescale 1ns / 1ps

package tpc_pkg;

   localparam int TIME_W     = 32;
   localparam int PRICE_W    = 24;
   localparam int COMM_W     = 8;
   localparam int CONTRACT_W = 14;
   localparam int WINDOW_W   = 12;
   localparam int CHG_W      = 21;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int ENTRY_W = TIME_W + PRICE_W;
   localparam int PROD_W  = 38;
   localparam int NUM_W   = 39;
   localparam int DEN_W   = 25;
   localparam int STEP_W  = 6;

   localparam logic [13:0] SCALE        = 14'd10000;
   localparam int          CHANGE_LIMIT = 1000000;

   localparam logic [CSR_IDX_W-1:0] REG_COMMODITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CONTRACT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW    = 2'd2;

   localparam logic [COMM_W-1:0]     RESET_COMMODITY = 8'd73;
   localparam logic [CONTRACT_W-1:0] RESET_CONTRACT  = 14'd2205;
   localparam logic [WINDOW_W-1:0]   RESET_WINDOW    = 12'd60;

   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [PRICE_W-1:0] price_type;

endpackage

// File: rtl/time_window_price_change.sv
// An accepted item steps through the states to its result. Each entry whose age is
// checked (every evicted entry and the first one kept) adds a read and a check, a zero
// base price skips the divider, and a held result stalls the output.
// One item at a time: the next one is accepted only once the result is issued; the
// 39-step restoring divider is the longest part. Unmatched ticks give no result.
// Reset is synchronous and active high; it empties the window and restores the registers.
`timescale 1ns / 1ps

module time_window_price_change #(
   parameter int WINDOW_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   // trade_time, trade_price, commodity_code, contract_number, zero fill
   input  logic [tpc_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // change_hundredths_pct, zero_base, dropped_on_full, zero fill
   output logic [tpc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tpc_pkg::CSR_DATA_W-1:0]  csr_data
);

   import tpc_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_DEPTH);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_EVRD   = 4'd1;
   localparam logic [3:0] ST_EVCHK  = 4'd2;
   localparam logic [3:0] ST_PUSH   = 4'd3;
   localparam logic [3:0] ST_RDBASE = 4'd4;
   localparam logic [3:0] ST_BASE   = 4'd5;
   localparam logic [3:0] ST_MUL    = 4'd6;
   localparam logic [3:0] ST_DIV    = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   logic [3:0]            state_ff, state_in;
   logic [COMM_W-1:0]     comm_ff, comm_in;
   logic [CONTRACT_W-1:0] contract_ff, contract_in;
   logic [WINDOW_W-1:0]   window_ff, window_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   time_type              time_ff, time_in;
   price_type             price_ff, price_in;
   logic                  dropped_ff, dropped_in;
   logic                  zero_ff, zero_in;
   logic                  neg_ff, neg_in;
   price_type             diff_ff, diff_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [DEN_W-1:0]      rem_ff, rem_in;
   logic [NUM_W-1:0]      quo_ff, quo_in;
   logic [STEP_W-1:0]     step_ff, step_in;

   logic [ENTRY_W-1:0]    rd_data;
   time_type              rd_time;
   price_type             rd_price;
   logic                  wr_en;
   logic                  accept;
   logic                  match;
   logic                  evict;
   logic [IDX_W-1:0]      head_next;
   logic [IDX_W-1:0]      tail_next;
   logic [PROD_W-1:0]     prod;
   logic [DEN_W:0]        trial;
   logic                  fits;
   logic [CHG_W-1:0]      mag;
   logic [CHG_W-1:0]      change;
   logic                  out_free;

   tpc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data ({time_ff, price_ff}),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign rd_time  = rd_data[ENTRY_W-1:PRICE_W];
   assign rd_price = rd_data[PRICE_W-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign match      = (req_tdata[63:56] == comm_ff) && (req_tdata[77:64] == contract_ff);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign wr_en      = (state_ff == ST_PUSH);

   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;

   assign evict = (time_ff > rd_time) && ((time_ff - rd_time) > TIME_W'(window_ff));

   assign prod  = PROD_W'(diff_ff) * PROD_W'(SCALE);
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   assign mag    = (quo_ff > NUM_W'(CHANGE_LIMIT)) ? CHG_W'(CHANGE_LIMIT) : quo_ff[CHG_W-1:0];
   assign change = neg_ff ? CHG_W'(-mag) : mag;

   always_comb begin
      comm_in     = comm_ff;
      contract_in = contract_ff;
      window_in   = window_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_COMMODITY: comm_in     = csr_data[COMM_W-1:0];
            REG_CONTRACT:  contract_in = csr_data[CONTRACT_W-1:0];
            REG_WINDOW:    window_in   = csr_data[WINDOW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      time_in      = time_ff;
      price_in     = price_ff;
      dropped_in   = dropped_ff;
      zero_in      = zero_ff;
      neg_in       = neg_ff;
      diff_in      = diff_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               time_in    = req_tdata[31:0];
               price_in   = req_tdata[55:32];
               dropped_in = 1'b0;
               if (match) begin
                  state_in = (count_ff != '0) ? ST_EVRD : ST_PUSH;
               end
            end
         end
         ST_EVRD: begin
            state_in = ST_EVCHK;
         end
         ST_EVCHK: begin
            if (evict) begin
               head_in  = head_next;
               count_in = count_ff - 1'b1;
               state_in = (count_ff == CNT_W'(1)) ? ST_PUSH : ST_EVRD;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            tail_in = tail_next;
            if (count_ff == FULL_CNT) begin
               head_in    = head_next;
               dropped_in = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
            state_in = ST_RDBASE;
         end
         ST_RDBASE: begin
            state_in = ST_BASE;
         end
         ST_BASE: begin
            neg_in  = price_ff < rd_price;
            diff_in = (price_ff < rd_price) ? rd_price - price_ff : price_ff - rd_price;
            den_in  = {rd_price, 1'b0};
            if (rd_price == '0) begin
               zero_in  = 1'b1;
               quo_in   = '0;
               state_in = ST_DONE;
            end else begin
               zero_in  = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            quo_in   = {prod, 1'b0} + NUM_W'(den_ff[DEN_W-1:1]);
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            quo_in  = {quo_ff[NUM_W-2:0], fits};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(NUM_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, dropped_ff, zero_ff, change};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         comm_ff      <= RESET_COMMODITY;
         contract_ff  <= RESET_CONTRACT;
         window_ff    <= RESET_WINDOW;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         comm_ff      <= comm_in;
         contract_ff  <= contract_in;
         window_ff    <= window_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      time_ff     <= time_in;
      price_ff    <= price_in;
      dropped_ff  <= dropped_in;
      zero_ff     <= zero_in;
      neg_ff      <= neg_in;
      diff_ff     <= diff_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("window count exceeds depth");

   a_empty_aligned: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty window with head and tail apart");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result item raised outside the final state");

   a_div_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (step_ff < STEP_W'(NUM_W)))
      else $error("divider ran past its step count");
`endif

endmodule

// File: rtl/tpc_ram.sv
`timescale 1ns / 1ps

module tpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
